FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Concurrent assertions that report through $error, with and without a reset
// qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Property checked only while the active-low reset is released.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/pdhc_pkg.sv
// ----------------------------------------------------------------------------
// pdhc_pkg
// Widths, constants, table entry layout and the FNV-1a step used by the
// packet duplicate filter.
// ----------------------------------------------------------------------------
package pdhc_pkg;

    // Table size and the widths that follow from it.
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int HASH_W = 64;
    localparam int TIME_W = 32;
    localparam int BYTE_W = 8;
    localparam int MAXE_W = 5;
    localparam int CAP_W  = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam int POS_W  = 4;

    // Configuration port.
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0] WINDOW_MS_RESET   = 32'd1000;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    // FNV-1a constants and the hop limit position.
    localparam logic [HASH_W-1:0] FNV_BASIS     = 64'hcbf29ce484222325;
    localparam logic [POS_W-1:0]  HOP_LIMIT_POS = 4'd7;
    localparam logic [POS_W-1:0]  POS_SAT       = 4'd8;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [TIME_W-1:0] stamp;
        logic [RANK_W-1:0] rank;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One FNV-1a step. The prime 0x100000001b3 is 2^40 plus 0x1b3, and
    // 0x1b3 has bits 0, 1, 4, 5, 7 and 8 set, so the product is a sum of shifts.
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] hash,
                                                   input logic [BYTE_W-1:0] data);
        logic [HASH_W-1:0] x;
        x = hash ^ {{(HASH_W-BYTE_W){1'b0}}, data};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

FILE: rtl/packet_dedup_hash_cache.sv
// ----------------------------------------------------------------------------
// packet_dedup_hash_cache: FNV-1a duplicate filter with a recency-ordered table.
// Non-last bytes are taken one per cycle, also while a table lookup runs.
// A last byte waits for an idle table; a hit then runs the scan sweep, decide, a rank-update
// sweep and emit; a miss runs scan, decide, expiry check, a drop sweep per expired entry and
// one for an eviction, insert and emit; each pass sweeps all slots through the RAM read port.
// Reset is synchronous: valid flags in flip-flops clear at once, no clearing pass.
// ----------------------------------------------------------------------------
module packet_dedup_hash_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Byte stream.
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [pdhc_pkg::BYTE_W-1:0]       i_packet_byte,
    input  logic                              i_last_byte,
    input  logic [pdhc_pkg::TIME_W-1:0]       i_now_ms,
    // Results.
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_is_duplicate,
    output logic [pdhc_pkg::HASH_W-1:0]       o_fingerprint,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [pdhc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pdhc_pkg::CFG_W-1:0]        i_cfg_wdata
);

    import pdhc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_HIT_UPD,
        S_EXP_CHK,
        S_DROP,
        S_INSERT,
        S_EMIT
    } t_state;

    t_state                r_state;

    // Configuration.
    logic [TIME_W-1:0]     r_window_ms;
    logic [MAXE_W-1:0]     r_max_entries;

    // Hashing of the byte stream.
    logic [HASH_W-1:0]     r_hash;
    logic [POS_W-1:0]      r_pos;
    logic [HASH_W-1:0]     n_hash;

    // Lookup context.
    logic [HASH_W-1:0]     r_fp;
    logic [TIME_W-1:0]     r_now;
    logic                  r_dup;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_slot;
    logic [RANK_W-1:0]     r_hit_rank;
    logic [TIME_W-1:0]     r_hit_time;
    logic [IDX_W-1:0]      r_old_slot;
    logic [TIME_W-1:0]     r_old_time;
    logic [IDX_W-1:0]      r_free;
    logic                  r_free_vld;
    logic                  r_evict;

    // Table bookkeeping kept in flip-flops.
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_count;

    // Sweep over the table memory.
    logic [CNT_W-1:0]      r_addr;
    logic                  r_pend;
    logic [IDX_W-1:0]      r_pidx;

    // Result register.
    logic                  r_out_valid;
    logic                  r_out_dup;
    logic [HASH_W-1:0]     r_out_fp;

    logic                  in_fire;
    logic                  in_sweep;
    logic                  issue;
    logic                  sweep_last;
    logic                  vis_valid;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                rd;
    t_entry                wr;
    logic [TIME_W-1:0]     old_age;
    logic [TIME_W-1:0]     hit_age;
    logic [CAP_W-1:0]      max_ext;
    logic [CAP_W-1:0]      cap;
    logic [CAP_W-1:0]      count_ext;

    // Table memory: fingerprint, time stamp and recency rank per slot.
    pdhc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A last byte needs the table; other bytes only touch the running hash.
    assign o_ready = !i_last_byte || (r_state == S_IDLE);
    assign in_fire = i_valid && o_ready;

    // Hop limit byte hashes as zero.
    assign n_hash = fnv_step(r_hash, (r_pos == HOP_LIMIT_POS) ? '0 : i_packet_byte);

    // Sweep address generation; data for r_pidx arrives while r_pend is high.
    assign in_sweep   = (r_state == S_SCAN) || (r_state == S_HIT_UPD) || (r_state == S_DROP);
    assign issue      = in_sweep && (r_addr < CNT_W'(TABLE_DEPTH));
    assign ram_raddr  = r_addr[IDX_W-1:0];
    assign rd         = ram_rdata;
    assign vis_valid  = r_valid[r_pidx];
    assign sweep_last = r_pend && (r_pidx == IDX_W'(TABLE_DEPTH - 1));

    // Ages modulo 2^32 and the clamped entry cap.
    assign old_age   = r_now - r_old_time;
    assign hit_age   = r_now - r_hit_time;
    assign max_ext   = CAP_W'(r_max_entries);
    assign count_ext = CAP_W'(r_count);

    always_comb begin
        if (max_ext == '0) begin
            cap = CAP_W'(1);
        end else if (max_ext > CAP_W'(TABLE_DEPTH)) begin
            cap = CAP_W'(TABLE_DEPTH);
        end else begin
            cap = max_ext;
        end
    end

    // Write-back of the memory: rank updates during sweeps, and the insert.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        wr        = rd;
        unique case (r_state)
            S_HIT_UPD: begin
                if (r_pend && (r_pidx == r_hit_slot)) begin
                    ram_we   = 1'b1;
                    wr.stamp = r_now;
                    wr.rank  = RANK_W'(r_count - 1'b1);
                end else if (r_pend && vis_valid && (rd.rank > r_hit_rank)) begin
                    ram_we  = 1'b1;
                    wr.rank = rd.rank - 1'b1;
                end
            end
            S_DROP: begin
                if (r_pend && vis_valid && (rd.rank != '0)) begin
                    ram_we  = 1'b1;
                    wr.rank = rd.rank - 1'b1;
                end
            end
            S_INSERT: begin
                ram_we    = 1'b1;
                ram_waddr = r_free;
                wr.hash   = r_fp;
                wr.stamp  = r_now;
                wr.rank   = RANK_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    // Control, table bookkeeping and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_ms   <= WINDOW_MS_RESET;
            r_max_entries <= MAX_ENTRIES_RESET;
            r_hash        <= FNV_BASIS;
            r_pos         <= '0;
            r_valid       <= '0;
            r_count       <= '0;
            r_addr        <= '0;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_WINDOW_MS:   r_window_ms   <= i_cfg_wdata[TIME_W-1:0];
                    REG_MAX_ENTRIES: r_max_entries <= i_cfg_wdata[MAXE_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Running hash over the accepted bytes.
            if (in_fire) begin
                if (i_last_byte) begin
                    r_hash <= FNV_BASIS;
                    r_pos  <= '0;
                end else begin
                    r_hash <= n_hash;
                    if (r_pos < POS_SAT) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
            end

            // Sweep pipeline.
            r_pend <= issue;
            r_pidx <= ram_raddr;
            if (issue) begin
                r_addr <= r_addr + 1'b1;
            end

            // Result taken downstream; the emit state reloads the register itself.
            if (r_out_valid && i_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire && i_last_byte) begin
                        r_fp       <= n_hash;
                        r_now      <= i_now_ms;
                        r_hit      <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_addr     <= '0;
                        r_state    <= S_SCAN;
                    end
                end

                // Find the match, the least recent entry and the lowest free slot.
                S_SCAN: begin
                    if (r_pend) begin
                        if (vis_valid) begin
                            if (!r_hit && (rd.hash == r_fp)) begin
                                r_hit      <= 1'b1;
                                r_hit_slot <= r_pidx;
                                r_hit_rank <= rd.rank;
                                r_hit_time <= rd.stamp;
                            end
                            if (rd.rank == '0) begin
                                r_old_slot <= r_pidx;
                                r_old_time <= rd.stamp;
                            end
                        end else if (!r_free_vld) begin
                            r_free     <= r_pidx;
                            r_free_vld <= 1'b1;
                        end
                    end
                    if (sweep_last) begin
                        r_state <= S_DECIDE;
                    end
                end

                S_DECIDE: begin
                    r_addr <= '0;
                    if (r_hit) begin
                        r_dup   <= (hit_age <= r_window_ms);
                        r_state <= S_HIT_UPD;
                    end else begin
                        r_dup   <= 1'b0;
                        r_evict <= 1'b0;
                        r_state <= S_EXP_CHK;
                    end
                end

                // Hit entry moves to the most recent rank.
                S_HIT_UPD: begin
                    if (sweep_last) begin
                        r_state <= S_EMIT;
                    end
                end

                // Expire the least recent entry, else evict it when full.
                S_EXP_CHK: begin
                    r_addr <= '0;
                    if ((r_count != '0) &&
                        ((old_age > r_window_ms) || (count_ext >= cap))) begin
                        r_evict               <= !(old_age > r_window_ms);
                        r_valid[r_old_slot]   <= 1'b0;
                        r_count               <= r_count - 1'b1;
                        if (!r_free_vld || (r_old_slot < r_free)) begin
                            r_free <= r_old_slot;
                        end
                        r_free_vld            <= 1'b1;
                        r_state               <= S_DROP;
                    end else begin
                        r_state <= S_INSERT;
                    end
                end

                // Shift ranks down and note the new least recent entry.
                S_DROP: begin
                    if (r_pend && vis_valid && (rd.rank == RANK_W'(1))) begin
                        r_old_slot <= r_pidx;
                        r_old_time <= rd.stamp;
                    end
                    if (sweep_last) begin
                        r_state <= r_evict ? S_INSERT : S_EXP_CHK;
                    end
                end

                S_INSERT: begin
                    r_valid[r_free] <= 1'b1;
                    r_count         <= r_count + 1'b1;
                    r_state         <= S_EMIT;
                end

                S_EMIT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_dup   <= r_dup;
                        r_out_fp    <= r_fp;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_is_duplicate = r_out_dup;
    assign o_fingerprint  = r_out_fp;

endmodule

FILE: rtl/pdhc_ram.sv
// ----------------------------------------------------------------------------
// pdhc_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered, so it appears in the cycle after the address.
// ----------------------------------------------------------------------------
module pdhc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pdhc_checker.sv
// ----------------------------------------------------------------------------
// pdhc_checker
// Port-level checks for the packet duplicate filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdhc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          i_last_byte,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic                          o_is_duplicate,
    input  logic [pdhc_pkg::HASH_W-1:0]   o_fingerprint
);

    // A stalled result holds its payload.
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_is_duplicate) && $stable(o_fingerprint)), "result changed while stalled")

    // Bytes other than the last one are never held back.
    `ASSERT_ALWAYS(a_body_ready, i_clk, (!i_last_byte) |-> o_ready, "body byte stalled")

    // Reset empties the result register.
    `ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_valid), "result valid after reset")

    // A packet end starts a lookup, so the next packet end must wait.
    `ASSERT_RUN(a_busy_after_end, i_clk, i_rst_n, (i_valid && o_ready && i_last_byte) |=> (!i_last_byte || !o_ready), "packet end taken during lookup")

endmodule

bind packet_dedup_hash_cache pdhc_checker u_pdhc_checker (.*);
